/* design/crf_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and helpers for the clipped rectangle fill block
// no dependencies
package crf_pkg;

  localparam int unsigned COLS_DEF = 32;
  localparam int unsigned ROWS_DEF = 8;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [8:0] COUNT_MAX  = 9'd511;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] fill_char;
  } crf_req_t;

  typedef struct packed {
    logic [7:0] cell_value;
    logic [8:0] cells_written;
    logic       out_of_range;
  } crf_res_t;

  // covered positions of [start, start+len) that lie below limit
  function automatic logic [8:0] span_inside(logic [7:0] start, logic [7:0] len,
                                             logic [8:0] limit);
    logic [8:0] end_v;
    logic [8:0] res;
    end_v = {1'b0, start} + {1'b0, len};
    if ({1'b0, start} >= limit) begin
      res = 9'd0;
    end else begin
      if (end_v > limit) begin
        end_v = limit;
      end
      res = end_v - {1'b0, start};
    end
    return res;
  endfunction

endpackage

/* design/crf_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for command and result beats
// no dependencies
interface crf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic [7:0] fill_char;

  modport source (output valid, op, pos_x, pos_y, rect_width, rect_height, fill_char,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_y, rect_width, rect_height, fill_char,
                  output ready);
endinterface

interface crf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_value;
  logic [8:0] cells_written;
  logic       out_of_range;

  modport source (output valid, cell_value, cells_written, out_of_range, input ready);
  modport sink   (input valid, cell_value, cells_written, out_of_range, output ready);
endinterface

/* design/crf_ram.sv */
`timescale 1ns / 1ps
// generic single-port ram with registered read
// no dependencies
module crf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/crf_seq.sv */
`timescale 1ns / 1ps
// command sequencer: clear sweep, clipped rectangle walk and cell read
// depends on crf_pkg
module crf_seq import crf_pkg::*; #(
  parameter int unsigned COLS = COLS_DEF,
  parameter int unsigned ROWS = ROWS_DEF,
  localparam int unsigned CELLS = ROWS * COLS,
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  crf_req_t      req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output crf_res_t      res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_addr_o,
  output logic [7:0]    mem_wdata_o,
  input  logic [7:0]    mem_rdata_i
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [8:0]    COLS9    = 9'(COLS);
  localparam logic [8:0]    ROWS9    = 9'(ROWS);
  localparam logic [AW-1:0] LAST     = AW'(CELLS - 1);
  localparam logic [8:0]    CLR_CNT  = (CELLS > 511) ? COUNT_MAX : 9'(CELLS);

  logic [2:0]    state_q, state_d;
  crf_req_t      req_q, req_d;
  crf_res_t      res_q, res_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [8:0]    cw_q, cw_d, ch_q, ch_d;
  logic [8:0]    col_q, col_d, row_q, row_d;

  logic [8:0]    cw_c, ch_c;
  logic [16:0]   base_full;
  logic [AW-1:0] base;
  logic [17:0]   prod;
  logic [AW:0]   row_step;

  always_comb begin
    cw_c      = span_inside(req_q.pos_x, req_q.rect_width, COLS9);
    ch_c      = span_inside(req_q.pos_y, req_q.rect_height, ROWS9);
    base_full = 17'(req_q.pos_y) * 17'(COLS9) + 17'(req_q.pos_x);
    base      = base_full[AW-1:0];
    prod      = 18'(cw_q) * 18'(ch_q);
    // jump from the last cell of a rectangle row to its first cell in the next row
    row_step  = (AW+1)'(addr_q) + (AW+1)'(1) + (AW+1)'(COLS9 - cw_q);
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    res_d   = res_q;
    addr_d  = addr_q;
    cw_d    = cw_q;
    ch_d    = ch_q;
    col_d   = col_q;
    row_d   = row_q;
    case (state_q)
      S_INIT: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        res_d = '0;
        cw_d  = cw_c;
        ch_d  = ch_c;
        col_d = 9'd0;
        row_d = 9'd0;
        case (req_q.op)
          OP_CLEAR: begin
            addr_d  = '0;
            state_d = S_CLEAR;
          end
          OP_FILL: begin
            addr_d = base;
            if (cw_c == 9'd0 || ch_c == 9'd0) begin
              state_d = S_DONE;
            end else begin
              state_d = S_FILL;
            end
          end
          OP_READ: begin
            if ({1'b0, req_q.pos_x} < COLS9 && {1'b0, req_q.pos_y} < ROWS9) begin
              state_d = S_RDWAIT;
            end else begin
              res_d.out_of_range = 1'b1;
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_FILL: begin
        res_d.cells_written = (prod > 18'(COUNT_MAX)) ? COUNT_MAX : prod[8:0];
        if (col_q == cw_q - 9'd1) begin
          col_d  = 9'd0;
          row_d  = row_q + 9'd1;
          addr_d = row_step[AW-1:0];
          if (row_q == ch_q - 9'd1) begin
            state_d = S_DONE;
          end
        end else begin
          col_d  = col_q + 9'd1;
          addr_d = addr_q + AW'(1);
        end
      end
      S_CLEAR: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST) begin
          res_d.cells_written = CLR_CNT;
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        res_d.cell_value = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    cw_q  <= cw_d;
    ch_q  <= ch_d;
    col_q <= col_d;
    row_q <= row_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  assign mem_we_o    = (state_q == S_INIT) || (state_q == S_CLEAR) || (state_q == S_FILL);
  assign mem_addr_o  = (state_q == S_SETUP) ? base : addr_q;
  assign mem_wdata_o = (state_q == S_FILL) ? req_q.fill_char : SPACE_CHAR;

endmodule

/* design/clipped_rectangle_fill_top.sv */
`timescale 1ns / 1ps
// clipped rectangle fill: character frame store with rectangle blitter
// depends on crf_pkg, crf_if, crf_ram, crf_seq
// one command at a time, one store cell written per cycle through the single ram port
// a read fetches one cell off the store, a fill writes cw*ch cells (cw, ch the clipped
// width and height), a clear writes all ROWS*COLS cells, an unused op writes none
// after reset a sweep writes spaces to every cell; no command beat is taken meanwhile
// a result moves into the output register once it is free; the next command may then start
module clipped_rectangle_fill_top import crf_pkg::*; #(
  parameter int unsigned COLS = COLS_DEF,
  parameter int unsigned ROWS = ROWS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  crf_in_if.sink    in_i,
  crf_out_if.source out_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  // command beat as a struct
  crf_req_t req;
  assign req.op          = in_i.op;
  assign req.pos_x       = in_i.pos_x;
  assign req.pos_y       = in_i.pos_y;
  assign req.rect_width  = in_i.rect_width;
  assign req.rect_height = in_i.rect_height;
  assign req.fill_char   = in_i.fill_char;

  // sequencer to ram
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // sequencer result handshake
  logic     res_valid;
  logic     res_ready;
  crf_res_t res;

  // output register
  logic     out_valid_q, out_valid_d;
  crf_res_t out_res_q, out_res_d;

  crf_seq #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // frame store, row-major
  crf_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cell_value    = out_res_q.cell_value;
  assign out_o.cells_written = out_res_q.cells_written;
  assign out_o.out_of_range  = out_res_q.out_of_range;

endmodule

/* tb/crf_checker.sv */
`timescale 1ns / 1ps
// result checker for the clipped rectangle fill block: keeps a shadow frame store,
// predicts each result beat and compares it with what comes out
// depends on crf_pkg and crf_if
module crf_checker import crf_pkg::*; #(
  parameter int unsigned COLS = COLS_DEF,
  parameter int unsigned ROWS = ROWS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  crf_in_if    cmd_mon,
  crf_out_if   res_mon,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int unsigned CELLS = COLS * ROWS;

  logic [7:0] shadow_store [CELLS];
  crf_res_t   expected_q [$];
  int         mismatches = 0;
  int         checked = 0;

  // part of [start, start+len) that stays below limit
  function automatic int unsigned clipped_span(int unsigned start, int unsigned len,
                                               int unsigned limit);
    if (start >= limit) return 0;
    return ((start + len > limit) ? limit : start + len) - start;
  endfunction

  function automatic logic [8:0] saturated_count(int unsigned n);
    return (n > COUNT_MAX) ? COUNT_MAX : 9'(n);
  endfunction

  // apply one command to the shadow store and return the result it should give
  function automatic crf_res_t apply_command(crf_req_t c);
    crf_res_t    r;
    int unsigned span_w;
    int unsigned span_h;
    r = '0;
    case (c.op)
      OP_CLEAR: begin
        for (int unsigned i = 0; i < CELLS; i++) shadow_store[i] = SPACE_CHAR;
        r.cells_written = saturated_count(CELLS);
      end
      OP_FILL: begin
        span_w = clipped_span(c.pos_x, c.rect_width, COLS);
        span_h = clipped_span(c.pos_y, c.rect_height, ROWS);
        for (int unsigned row = 0; row < span_h; row++) begin
          for (int unsigned col = 0; col < span_w; col++) begin
            shadow_store[(c.pos_y + row) * COLS + c.pos_x + col] = c.fill_char;
          end
        end
        r.cells_written = saturated_count(span_w * span_h);
      end
      OP_READ: begin
        if (c.pos_x < COLS && c.pos_y < ROWS) begin
          r.cell_value = shadow_store[c.pos_y * COLS + c.pos_x];
        end else begin
          r.out_of_range = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    crf_res_t want;
    crf_res_t got;
    crf_req_t cmd;
    if (!rst_ni) begin
      foreach (shadow_store[i]) shadow_store[i] = SPACE_CHAR;
      expected_q.delete();
    end else begin
      // result side first: a beat at this edge cannot belong to a command taken now
      if (res_mon.valid && res_mon.ready) begin
        got.cell_value    = res_mon.cell_value;
        got.cells_written = res_mon.cells_written;
        got.out_of_range  = res_mon.out_of_range;
        checked++;
        if (expected_q.size() == 0) begin
          log_mismatch($sformatf("unexpected beat value=%02h count=%0d oor=%0b",
                                 got.cell_value, got.cells_written, got.out_of_range));
        end else begin
          want = expected_q.pop_front();
          if (got.cell_value !== want.cell_value ||
              got.cells_written !== want.cells_written ||
              got.out_of_range !== want.out_of_range) begin
            log_mismatch($sformatf(
              "beat %0d expected value=%02h count=%0d oor=%0b, got value=%02h count=%0d oor=%0b",
              checked, want.cell_value, want.cells_written, want.out_of_range,
              got.cell_value, got.cells_written, got.out_of_range));
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        cmd.op          = cmd_mon.op;
        cmd.pos_x       = cmd_mon.pos_x;
        cmd.pos_y       = cmd_mon.pos_y;
        cmd.rect_width  = cmd_mon.rect_width;
        cmd.rect_height = cmd_mon.rect_height;
        cmd.fill_char   = cmd_mon.fill_char;
        expected_q.push_back(apply_command(cmd));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_q.size();
    checked_o        <= checked;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// top of the clipped rectangle fill testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict
// depends on crf_pkg, crf_if, crf_checker and clipped_rectangle_fill_top
module tb_top;
  import crf_pkg::*;

  // the fourth selector value has no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_CMDS    = 1580;
  localparam int CALM_TAIL      = 200;   // last commands run with no idling at all
  // worst quiet stretch: the post-reset sweep or a full clear plus result stall bursts
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;   // beyond the longest command latency

  logic clk_i;
  logic rst_ni;

  crf_in_if  cmd_if ();
  crf_out_if res_if ();

  int mismatch_count;
  int pending;
  int checked;
  int idle_cycles = 0;
  bit calm_tail   = 1'b0;
  int n_fill      = 0;
  int n_read      = 0;
  int n_clear     = 0;
  int n_unused    = 0;

  clipped_rectangle_fill_top #(
    .COLS (COLS_DEF),
    .ROWS (ROWS_DEF)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  crf_checker #(
    .COLS (COLS_DEF),
    .ROWS (ROWS_DEF)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_mon          (cmd_if),
    .res_mon          (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: ends the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles, %0d results still owed",
               $realtime, idle_cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // result back-pressure: random stall bursts with ready low, the stall rate itself
  // wanders so that some stretches have no stalls at all
  initial begin : res_stall
    int stall_left;
    int stall_pct;
    stall_left = 0;
    stall_pct  = 15;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) stall_pct = $urandom_range(0, 2) * 15;
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm_tail && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
          stall_left = $urandom_range(1, 14);
        end
      end
    end
  end

  function automatic crf_req_t mk_cmd(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                      logic [7:0] w, logic [7:0] h, logic [7:0] ch);
    crf_req_t c;
    c.op          = op;
    c.pos_x       = x;
    c.pos_y       = y;
    c.rect_width  = w;
    c.rect_height = h;
    c.fill_char   = ch;
    return c;
  endfunction

  // mostly rectangles and reads around the store so that fills land and reads
  // see them; now and then the full 8-bit range for far-off clipping
  function automatic crf_req_t random_cmd();
    crf_req_t c;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)       c.op = OP_UNUSED;
    else if (pick < 5)  c.op = OP_CLEAR;
    else if (pick < 42) c.op = OP_FILL;
    else                c.op = OP_READ;
    c.pos_x       = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, COLS_DEF + 3));
    c.pos_y       = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, ROWS_DEF + 2));
    c.rect_width  = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 10));
    c.rect_height = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 5));
    c.fill_char   = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // one command beat; an optional random gap drops valid beforehand
  task automatic issue_command(input crf_req_t c);
    int gap;
    gap = 0;
    if (!calm_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.op          <= c.op;
    cmd_if.pos_x       <= c.pos_x;
    cmd_if.pos_y       <= c.pos_y;
    cmd_if.rect_width  <= c.rect_width;
    cmd_if.rect_height <= c.rect_height;
    cmd_if.fill_char   <= c.fill_char;
    do @(posedge clk_i); while (!cmd_if.ready);
    case (c.op)
      OP_CLEAR: n_clear++;
      OP_FILL:  n_fill++;
      OP_READ:  n_read++;
      default:  n_unused++;
    endcase
  endtask

  initial begin : stimulus
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.op          = OP_CLEAR;
    cmd_if.pos_x       = '0;
    cmd_if.pos_y       = '0;
    cmd_if.rect_width  = '0;
    cmd_if.rect_height = '0;
    cmd_if.fill_char   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, store corners, reads off the store
    issue_command(mk_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    issue_command(mk_cmd(OP_READ, 8'd31, 8'd7, 8'd0, 8'd0, 8'd0));
    issue_command(mk_cmd(OP_READ, 8'd32, 8'd0, 8'd0, 8'd0, 8'd0));
    issue_command(mk_cmd(OP_READ, 8'd0, 8'd8, 8'd0, 8'd0, 8'd0));
    issue_command(mk_cmd(OP_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    // empty rectangles, zero width and zero height
    issue_command(mk_cmd(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd5, 8'h5a));
    issue_command(mk_cmd(OP_FILL, 8'd0, 8'd0, 8'd5, 8'd0, 8'h5a));
    // oversized rectangle clipped to the whole store
    issue_command(mk_cmd(OP_FILL, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff));
    issue_command(mk_cmd(OP_READ, 8'd17, 8'd3, 8'd0, 8'd0, 8'd0));
    // rectangle hanging over the bottom-right corner
    issue_command(mk_cmd(OP_FILL, 8'd30, 8'd6, 8'd5, 8'd5, 8'h41));
    issue_command(mk_cmd(OP_READ, 8'd31, 8'd7, 8'd0, 8'd0, 8'd0));
    issue_command(mk_cmd(OP_READ, 8'd29, 8'd7, 8'd0, 8'd0, 8'd0));
    // origin far outside, no wrap-around
    issue_command(mk_cmd(OP_FILL, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00));
    issue_command(mk_cmd(OP_FILL, 8'd5, 8'd2, 8'd1, 8'd1, 8'h00));
    issue_command(mk_cmd(OP_READ, 8'd5, 8'd2, 8'd0, 8'd0, 8'd0));
    // unused selector must leave the store alone
    issue_command(mk_cmd(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    issue_command(mk_cmd(OP_READ, 8'd5, 8'd2, 8'd0, 8'd0, 8'd0));
    issue_command(mk_cmd(OP_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    issue_command(mk_cmd(OP_READ, 8'd5, 8'd2, 8'd0, 8'd0, 8'd0));
    // single column down the right edge
    issue_command(mk_cmd(OP_FILL, 8'd31, 8'd0, 8'd1, 8'd8, 8'h80));
    issue_command(mk_cmd(OP_READ, 8'd31, 8'd4, 8'd0, 8'd0, 8'd0));

    // random part, idling switched off for the tail
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      calm_tail = (i >= RANDOM_CMDS - CALM_TAIL);
      issue_command(random_cmd());
    end
    cmd_if.valid <= 1'b0;

    // let the last beat reach the checker, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d commands: %0d fills, %0d reads, %0d clears, %0d unused-op",
             n_fill + n_read + n_clear + n_unused, n_fill, n_read, n_clear, n_unused);
    $display("%0d result beats checked, incl. edge clipping, empty and off-store cases",
             checked);
    if (mismatch_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* clipped_rectangle_fill_top.f */
design/crf_pkg.sv
design/crf_if.sv
design/crf_ram.sv
design/crf_seq.sv
design/clipped_rectangle_fill_top.sv
tb/crf_checker.sv
tb/tb_top.sv
